>>> src/rational_arith_reduce_unit_assert.svh
// Assertion macros shared by the block's modules.
`ifndef RATIONAL_ARITH_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_REDUCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RAR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rar_pkg.sv
package rar_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DIV = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MS_AX = 2'd0,
    MS_BC = 2'd1,
    MS_BD = 2'd2
  } mul_sel_t;

  typedef enum logic {
    DS_NUM = 1'b0,
    DS_DEN = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     sum;
    logic     norm;
    logic     gcd_step;
    logic     div_init;
    div_sel_t div_sel;
    logic     div_step;
    logic     num_store;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic zero;
    logic gcd_done;
    logic div_last;
  } sts_t;

  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

endpackage

>>> src/rar_if.sv
interface rar_req_if import rar_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                req_type;
  logic signed [31:0] left_num;
  logic signed [31:0] left_den;
  logic signed [31:0] right_num;
  logic signed [31:0] right_den;

  modport source (
    output valid, req_type, left_num, left_den, right_num, right_den,
    input  ready
  );
  modport sink (
    input  valid, req_type, left_num, left_den, right_num, right_den,
    output ready
  );
endinterface

interface rar_rsp_if import rar_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [31:0] result_num;
  logic [30:0]        result_den;
  status_t            status;

  modport source (
    output valid, result_num, result_den, status,
    input  ready
  );
  modport sink (
    input  valid, result_num, result_den, status,
    output ready
  );
endinterface

>>> src/rational_arith_reduce_unit.sv
// Rational arithmetic unit with reduction to lowest terms.
// The req channel carries one transaction per operation: an opcode (add, subtract,
// multiply, divide) and two fractions as signed 32-bit numerators and denominators.
// The rsp channel returns one transaction per request: the reduced numerator with
// its sign, a positive 31-bit denominator and a status code (ok, zero denominator
// or divisor, result too wide for 32 bits). On an error both result fields are zero.
// One request is worked on at a time. Three cross products come from a single
// 32x32 multiplier, then a binary GCD over 64-bit magnitudes runs one shift or
// subtract per cycle, then one restoring divider makes two exact 64-bit divisions.
// An error result skips everything after the first product, and a zero numerator
// skips the GCD and the divisions. The next request is accepted in the cycle after
// the previous result has been registered.
// The result sits in an output register, so a new request is accepted as soon as
// the previous one has been handed there, even while the receiver stalls; the
// block waits only if a finished result still finds that register full.
// A synchronous reset clears the controller and drops rsp valid.
module rational_arith_reduce_unit import rar_pkg::*; (
  input logic  clk,
  input logic  rst,
  rar_req_if.sink   req,
  rar_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  rar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rar_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .left_num   (req.left_num),
    .left_den   (req.left_den),
    .right_num  (req.right_num),
    .right_den  (req.right_den),
    .result_num (rsp.result_num),
    .result_den (rsp.result_den),
    .status     (rsp.status)
  );

endmodule

>>> src/rar_ctrl.sv
`include "rational_arith_reduce_unit_assert.svh"

module rar_ctrl import rar_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  output logic rsp_valid,
  input  logic rsp_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SUM,
    S_NORM,
    S_TEST,
    S_GCD,
    S_DIVN_INIT,
    S_DIVN,
    S_DIVD_INIT,
    S_DIVD,
    S_FIN
  } state_t;

  state_t state;
  logic   slot_free;

  assign req_ready = (state == S_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = MS_AX;
    cmd.div_sel = DS_NUM;
    unique case (state)
      S_IDLE: begin
        cmd.load = req_valid;
      end
      S_MUL0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_AX;
      end
      S_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_BC;
      end
      S_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = MS_BD;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
      end
      S_NORM: begin
        cmd.norm = 1'b1;
      end
      S_TEST: begin
      end
      S_GCD: begin
        cmd.gcd_step = 1'b1;
      end
      S_DIVN_INIT: begin
        cmd.div_init = 1'b1;
        cmd.div_sel = DS_NUM;
      end
      S_DIVN: begin
        cmd.div_step = 1'b1;
      end
      S_DIVD_INIT: begin
        cmd.num_store = 1'b1;
        cmd.div_init = 1'b1;
        cmd.div_sel = DS_DEN;
      end
      S_DIVD: begin
        cmd.div_step = 1'b1;
      end
      S_FIN: begin
        cmd.out_load = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= cmd.out_load || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_MUL0;
          end
        end
        S_MUL0: begin
          state <= sts.err ? S_FIN : S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_NORM;
        end
        S_NORM: begin
          state <= S_TEST;
        end
        S_TEST: begin
          state <= sts.zero ? S_FIN : S_GCD;
        end
        S_GCD: begin
          if (sts.gcd_done) begin
            state <= S_DIVN_INIT;
          end
        end
        S_DIVN_INIT: begin
          state <= S_DIVN;
        end
        S_DIVN: begin
          if (sts.div_last) begin
            state <= S_DIVD_INIT;
          end
        end
        S_DIVD_INIT: begin
          state <= S_DIVD;
        end
        S_DIVD: begin
          if (sts.div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RAR_ASSERT_NOW(a_out_slot_free, cmd.out_load, slot_free, "result loaded over a pending transaction")
  `RAR_ASSERT_NOW(a_one_phase, cmd.div_step, !cmd.div_init && !cmd.gcd_step, "divider stepped while reloading")

endmodule

>>> src/rar_dp.sv
`include "rational_arith_reduce_unit_assert.svh"

module rar_dp import rar_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  op_t                req_type,
  input  logic signed [31:0] left_num,
  input  logic signed [31:0] left_den,
  input  logic signed [31:0] right_num,
  input  logic signed [31:0] right_den,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output status_t            status
);

  op_t         op;
  logic        an, bn, cn, dn;
  logic [31:0] am, bm, cm, dm;
  logic        err;
  logic [31:0] in_am, in_bm, in_cm, in_dm;

  logic [63:0] prod_ax, prod_bc, prod_bd;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [64:0] raw;
  logic        nneg, dneg;
  logic [63:0] nm, den;
  logic        pn, qn;

  logic [63:0] u, v, g;
  logic [5:0]  k;
  logic        u_zero, v_zero;
  logic [64:0] diff_uv;
  logic [63:0] diff_vu;

  logic [63:0] rem, dq, nq;
  logic [5:0]  cnt;
  logic [64:0] shifted, trial;

  logic        neg, ovf;

  assign in_am = mag32(left_num);
  assign in_bm = mag32(left_den);
  assign in_cm = mag32(right_num);
  assign in_dm = mag32(right_den);

  always_comb begin
    mul_a = bm;
    mul_b = dm;
    case (cmd.mul_sel)
      MS_AX: begin
        mul_a = am;
        mul_b = (op == OP_MUL) ? cm : dm;
      end
      MS_BC: begin
        mul_a = bm;
        mul_b = cm;
      end
      default: begin
        mul_a = bm;
        mul_b = dm;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  assign pn = an ^ dn;
  assign qn = bn ^ cn ^ (op == OP_SUB);

  assign u_zero = (u == '0);
  assign v_zero = (v == '0);
  assign diff_uv = {1'b0, u} - {1'b0, v};
  assign diff_vu = v - u;

  assign shifted = {rem, dq[63]};
  assign trial = shifted - {1'b0, g};

  assign neg = nneg ^ dneg;
  assign ovf = (|dq[63:31]) ||
               (neg ? ((|nq[63:32]) || (nq[31] && (|nq[30:0]))) : (|nq[63:31]));

  assign sts.err = err;
  assign sts.zero = (nm == '0);
  assign sts.gcd_done = u_zero || v_zero;
  assign sts.div_last = (cnt == '1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= req_type;
      an <= left_num[31];
      bn <= left_den[31];
      cn <= right_num[31];
      dn <= right_den[31];
      am <= in_am;
      bm <= in_bm;
      cm <= in_cm;
      dm <= in_dm;
      err <= (in_bm == '0) || (in_dm == '0) || ((req_type == OP_DIV) && (in_cm == '0));
    end

    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MS_AX: prod_ax <= mul_p;
        MS_BC: prod_bc <= mul_p;
        default: prod_bd <= mul_p;
      endcase
    end

    if (cmd.sum) begin
      case (op) inside
        OP_ADD, OP_SUB: begin
          raw <= (pn == qn) ? ({1'b0, prod_ax} + {1'b0, prod_bc})
                            : ({1'b0, prod_ax} - {1'b0, prod_bc});
          nneg <= pn;
          den <= prod_bd;
          dneg <= bn ^ dn;
        end
        OP_MUL: begin
          raw <= {1'b0, prod_ax};
          nneg <= an ^ cn;
          den <= prod_bd;
          dneg <= bn ^ dn;
        end
        default: begin
          raw <= {1'b0, prod_ax};
          nneg <= an ^ dn;
          den <= prod_bc;
          dneg <= bn ^ cn;
        end
      endcase
    end

    // A negative difference is turned back into a magnitude here.
    if (cmd.norm) begin
      if (raw[64]) begin
        nm <= 64'd0 - raw[63:0];
        u <= 64'd0 - raw[63:0];
        nneg <= ~nneg;
      end else begin
        nm <= raw[63:0];
        u <= raw[63:0];
      end
      v <= den;
      k <= '0;
    end

    if (cmd.gcd_step) begin
      if (u_zero || v_zero) begin
        g <= (u_zero ? v : u) << k;
      end else if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 6'd1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (!diff_uv[64]) begin
        u <= diff_uv[64:1];
      end else begin
        v <= diff_vu >> 1;
      end
    end

    if (cmd.num_store) begin
      nq <= dq;
    end

    if (cmd.div_init) begin
      dq <= (cmd.div_sel == DS_DEN) ? den : nm;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        dq <= {dq[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        dq <= {dq[62:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
    end

    if (cmd.out_load) begin
      if (err) begin
        result_num <= '0;
        result_den <= '0;
        status <= ST_ZERO_DIV;
      end else if (nm == '0) begin
        result_num <= '0;
        result_den <= 31'd1;
        status <= ST_OK;
      end else if (ovf) begin
        result_num <= '0;
        result_den <= '0;
        status <= ST_OVERFLOW;
      end else begin
        result_num <= neg ? (32'd0 - nq[31:0]) : nq[31:0];
        result_den <= dq[30:0];
        status <= ST_OK;
      end
    end
  end

  `RAR_ASSERT_NEXT(a_gcd_nonzero, cmd.gcd_step && !sts.gcd_done, !u_zero || !v_zero, "GCD operands both reached zero")
  `RAR_ASSERT_NOW(a_gcd_shift_range, cmd.gcd_step && !sts.gcd_done && !u[0] && !v[0], k != '1, "GCD common shift overflowed")
  `RAR_ASSERT_NOW(a_num_exact, cmd.num_store, rem == '0, "numerator not divided exactly by the GCD")
  `RAR_ASSERT_NOW(a_den_exact, cmd.out_load && !err && (nm != '0), rem == '0, "denominator not divided exactly by the GCD")

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rar_pkg::*;

  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_NEG1 = -32'sd1;
  localparam int RANDOM_PER_PHASE = 450;
  localparam int HOLD_AT_RESULT = 700;
  localparam int HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    status_t            st;
  } frac_res_t;

  typedef struct {
    op_t                op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    bit                 fixed_res;
    frac_res_t          res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  rar_req_if req_ch();
  rar_rsp_if rsp_ch();

  rational_arith_reduce_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  frac_res_t pending_fracs[$];
  frac_res_t want;
  int        n_fail = 0;
  int        rsp_seen = 0;
  int        req_idle_pct = 0;
  int        rsp_stall_pct = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [63:0] mag_of(input logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic frac_res_t reduce_rational(input op_t op, input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] c,
                                                input logic signed [31:0] d);
    logic [63:0]        am, bm, cm, dm, nmag, dmag, x, y, t;
    logic signed [65:0] ps, qs, s;
    logic               nneg, dneg, neg;
    frac_res_t          r;
    r = '{num: '0, den: '0, st: ST_OK};
    am = mag_of(a);
    bm = mag_of(b);
    cm = mag_of(c);
    dm = mag_of(d);
    if (bm == 0 || dm == 0 || (op == OP_DIV && cm == 0)) begin
      r.st = ST_ZERO_DIV;
      return r;
    end
    case (op)
      OP_ADD, OP_SUB: begin
        ps = $signed({2'b00, am * dm});
        qs = $signed({2'b00, bm * cm});
        if (a[31] ^ d[31]) ps = -ps;
        if (b[31] ^ c[31] ^ (op == OP_SUB)) qs = -qs;
        s = ps + qs;
        nneg = s < 0;
        if (nneg) s = -s;
        nmag = s[63:0];
        dmag = bm * dm;
        dneg = b[31] ^ d[31];
      end
      OP_MUL: begin
        nmag = am * cm;
        nneg = a[31] ^ c[31];
        dmag = bm * dm;
        dneg = b[31] ^ d[31];
      end
      default: begin
        nmag = am * dm;
        nneg = a[31] ^ d[31];
        dmag = bm * cm;
        dneg = b[31] ^ c[31];
      end
    endcase
    if (nmag == 0) begin
      r.den = 31'd1;
      return r;
    end
    x = nmag;
    y = dmag;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nmag = nmag / x;
    dmag = dmag / x;
    neg = nneg ^ dneg;
    if (dmag > 64'h7FFF_FFFF || nmag > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      r.st = ST_OVERFLOW;
      return r;
    end
    r.num = nmag[31:0];
    if (neg) r.num = -r.num;
    r.den = dmag[30:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rand_operand();
    logic signed [31:0] v;
    case ($urandom_range(15))
      0: v = '0;
      1: v = S32_MIN;
      2: v = $urandom_range(1) ? S32_MAX : S32_NEG1;
      3, 4, 5, 6: v = $signed($urandom_range(40)) - 20;
      7, 8, 9: v = $urandom;
      10, 11, 12: v = $urandom_range(2000) * (1 << $urandom_range(12));
      default: v = $urandom >> $urandom_range(31);
    endcase
    if (v != S32_MIN && $urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_frac(input op_t op, input logic signed [31:0] a,
                           input logic signed [31:0] b, input logic signed [31:0] c,
                           input logic signed [31:0] d);
    while ($urandom_range(99) < req_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= op;
    req_ch.left_num  <= a;
    req_ch.left_den  <= b;
    req_ch.right_num <= c;
    req_ch.right_den <= d;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  // The receiver holds off once for a long stretch so that the block backs up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && rsp_seen >= HOLD_AT_RESULT) begin
      rsp_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      rsp_seen <= rsp_seen + 1;
      if (pending_fracs.size() == 0) begin
        $display("%0t: unexpected transaction num=%0d den=%0d status=%0d", $time,
                 rsp_ch.result_num, rsp_ch.result_den, rsp_ch.status);
        n_fail++;
      end else begin
        want = pending_fracs.pop_front();
        if (rsp_ch.result_num !== want.num || rsp_ch.result_den !== want.den ||
            rsp_ch.status !== want.st) begin
          $display("%0t: expected num=%0d den=%0d status=%0d, got num=%0d den=%0d status=%0d",
                   $time, want.num, want.den, want.st,
                   rsp_ch.result_num, rsp_ch.result_den, rsp_ch.status);
          n_fail++;
        end
      end
    end
  end

  initial begin
    dir_row_t           dir_rows [24];
    op_t                op;
    logic signed [31:0] a, b, c, d;
    dir_rows = '{
      '{OP_ADD, 0, 1, 0, 1, 1'b1, '{0, 1, ST_OK}},
      '{OP_ADD, 1, 0, 1, 1, 1'b1, '{0, 0, ST_ZERO_DIV}},
      '{OP_MUL, 1, 1, 1, 0, 1'b1, '{0, 0, ST_ZERO_DIV}},
      '{OP_DIV, S32_MAX, S32_MIN, 1, 0, 1'b1, '{0, 0, ST_ZERO_DIV}},
      '{OP_DIV, 5, 3, 0, 7, 1'b1, '{0, 0, ST_ZERO_DIV}},
      '{OP_DIV, 0, 0, 0, 0, 1'b1, '{0, 0, ST_ZERO_DIV}},
      '{OP_SUB, 4, 4, 0, 5, 1'b1, '{1, 1, ST_OK}},
      '{OP_MUL, 2, 4, 2, 4, 1'b1, '{1, 4, ST_OK}},
      '{OP_MUL, S32_MIN, 1, 1, 1, 1'b1, '{S32_MIN, 1, ST_OK}},
      '{OP_MUL, S32_MAX, 1, 1, 1, 1'b1, '{S32_MAX, 1, ST_OK}},
      '{OP_MUL, S32_MIN, S32_NEG1, 1, 1, 1'b1, '{0, 0, ST_OVERFLOW}},
      '{OP_DIV, 1, S32_MIN, 1, 1, 1'b1, '{0, 0, ST_OVERFLOW}},
      '{OP_ADD, S32_MAX, 1, S32_MAX, 1, 1'b1, '{0, 0, ST_OVERFLOW}},
      '{OP_SUB, S32_MIN, S32_MIN, S32_MAX, S32_MAX, 1'b1, '{0, 1, ST_OK}},
      '{OP_MUL, S32_NEG1, S32_NEG1, S32_NEG1, S32_NEG1, 1'b1, '{1, 1, ST_OK}},
      '{OP_DIV, 1, 1, 1, S32_NEG1, 1'b1, '{S32_NEG1, 1, ST_OK}},
      '{OP_ADD, S32_NEG1, S32_NEG1, S32_NEG1, S32_NEG1, 1'b1, '{2, 1, ST_OK}},
      '{OP_DIV, S32_MIN, S32_MIN, S32_MIN, S32_MIN, 1'b1, '{1, 1, ST_OK}},
      '{OP_ADD, 1, S32_MAX, 1, S32_MIN, 1'b0, '{0, 0, ST_OK}},
      '{OP_SUB, S32_MIN, S32_MAX, S32_MAX, S32_MIN, 1'b0, '{0, 0, ST_OK}},
      '{OP_MUL, S32_MAX, S32_MIN, S32_MIN, S32_MAX, 1'b0, '{0, 0, ST_OK}},
      '{OP_DIV, -3, 7, 9, -14, 1'b0, '{0, 0, ST_OK}},
      '{OP_ADD, -1, 2, 1, 3, 1'b0, '{0, 0, ST_OK}},
      '{OP_SUB, 32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0,
        '{0, 0, ST_OK}}
    };
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.req_type  = OP_ADD;
    req_ch.left_num  = '0;
    req_ch.left_den  = '0;
    req_ch.right_num = '0;
    req_ch.right_den = '0;
    rsp_ch.ready     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_frac(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].d);
      pending_fracs.push_back(dir_rows[i].fixed_res ? dir_rows[i].res :
                              reduce_rational(dir_rows[i].op, dir_rows[i].a, dir_rows[i].b,
                                              dir_rows[i].c, dir_rows[i].d));
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin req_idle_pct = 71; rsp_stall_pct = 0;  end
        2: begin req_idle_pct = 0;  rsp_stall_pct = 71; end
        default: begin req_idle_pct = 16; rsp_stall_pct = 16; end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        op = op_t'($urandom_range(3));
        a  = rand_operand();
        b  = rand_operand();
        c  = rand_operand();
        d  = rand_operand();
        send_frac(op, a, b, c, d);
        pending_fracs.push_back(reduce_rational(op, a, b, c, d));
      end
    end
    req_ch.valid <= 1'b0;

    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
